@@ rtl/vts_pkg.sv @@
// Shared types, field widths and codes for the video transition shape block.
package vts_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int KIND_W     = 3;
   localparam int DIR_W      = 2;
   localparam int SOFT_W     = 17;
   localparam int DIM_REG_W  = 14;
   localparam int PROG_W     = 18;
   localparam int Q16_W      = 17;
   localparam int ROOT2_W    = 31;

   localparam int OFS_W      = 23;
   localparam int OP_W       = 17;
   localparam int SHAPE_W    = 2;
   localparam int FEATHER_W  = 22;
   localparam int MASK_W     = 25;
   localparam int CENTRE_W   = 24;

   localparam logic [Q16_W-1:0]     ONE_Q16     = 17'd65536;
   localparam logic [Q16_W-1:0]     HALF_Q16    = 17'd32768;
   localparam logic [Q16_W:0]       HALF_Q17    = 18'd65536;
   localparam logic [29:0]          HALF_Q30    = 30'd536870912;
   localparam logic [ROOT2_W-1:0]   ROOT2_Q30   = 31'd1518500250;
   localparam logic [FEATHER_W-1:0] FEATHER_MAX = 22'h3FFFFF;

   localparam logic [KIND_W-1:0] KIND_DISSOLVE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WIPE     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SLIDE    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PUSH     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_IRIS     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ZOOM     = 3'd5;
   localparam logic [KIND_W-1:0] KIND_DIP      = 3'd6;

   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

   localparam logic [SHAPE_W-1:0] SHAPE_NONE    = 2'd0;
   localparam logic [SHAPE_W-1:0] SHAPE_RECT    = 2'd1;
   localparam logic [SHAPE_W-1:0] SHAPE_ELLIPSE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_KIND      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFTNESS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 3'd4;

   localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 14'd1920;
   localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 14'd1080;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [DIR_W-1:0]     direction;
      logic [SOFT_W-1:0]    softness;
      logic [DIM_REG_W-1:0] frame_width;
      logic [DIM_REG_W-1:0] frame_height;
   } cfg_type;

endpackage

@@ rtl/vts_front.sv @@
// Front pipeline stages: progress clamp, first multiplier rank and rounding.
module vts_front #(
   parameter int PIX_W = 22
) (
   input  logic                    clock,
   input  logic                    reset,
   input  vts_pkg::cfg_type        cfg,
   input  logic [PIX_W-1:0]        wq,
   input  logic [PIX_W-1:0]        hq,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [17:0]      req_progress,
   output logic                    s3_valid,
   input  logic                    s3_ready,
   output logic [16:0]             s3_t,
   output logic [PIX_W-1:0]        s3_f,
   output logic [PIX_W+1:0]        s3_ax,
   output logic [PIX_W+1:0]        s3_ay,
   output logic [PIX_W-1:0]        s3_inc,
   output logic [PIX_W-1:0]        s3_outc
);
   import vts_pkg::*;

   localparam int PROD_F_W = PIX_W + SOFT_W;
   localparam int PROD_G_W = PIX_W + ROOT2_W;
   localparam int PROD_D_W = PIX_W + Q16_W;
   localparam int AX_W     = PIX_W + 2;

   logic stage1_ready, stage2_ready, stage3_ready;
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;

   logic [Q16_W-1:0]    t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   logic [PROD_F_W-1:0] prod_f2_ff, prod_f2_in;
   logic [PROD_G_W-1:0] prod_gw2_ff, prod_gw2_in, prod_gh2_ff, prod_gh2_in;
   logic [PROD_D_W-1:0] prod_in2_ff, prod_in2_in, prod_out2_ff, prod_out2_in;
   logic [PIX_W-1:0]    f3_ff, f3_in, inc3_ff, inc3_in, outc3_ff, outc3_in;
   logic [AX_W-1:0]     ax3_ff, ax3_in, ay3_ff, ay3_in;

   logic                horizontal;
   logic [PIX_W-1:0]    tr, fdim;
   logic [SOFT_W-1:0]   s_sat;
   logic [Q16_W-1:0]    rest_t;
   logic [PROD_F_W:0]   f_sum;
   logic [PROD_G_W:0]   gw_sum, gh_sum;
   logic [PROD_D_W:0]   inc_sum, outc_sum;
   logic [PIX_W:0]      gw, gh;

   assign stage3_ready = !v3_ff || s3_ready;
   assign stage2_ready = !v2_ff || stage3_ready;
   assign stage1_ready = !v1_ff || stage2_ready;
   assign req_ready    = stage1_ready;

   assign v1_in = stage1_ready ? req_valid : v1_ff;
   assign v2_in = stage2_ready ? v1_ff : v2_ff;
   assign v3_in = stage3_ready ? v2_ff : v3_ff;

   assign horizontal = (cfg.direction == DIR_RIGHT) || (cfg.direction == DIR_LEFT);
   assign tr         = horizontal ? wq : hq;

   always_comb begin
      if (req_progress[PROG_W-1]) begin
         t1_in = '0;
      end else if (req_progress[Q16_W-1:0] > ONE_Q16) begin
         t1_in = ONE_Q16;
      end else begin
         t1_in = req_progress[Q16_W-1:0];
      end
   end

   always_comb begin
      if (cfg.kind == KIND_IRIS) begin
         fdim = (wq < hq) ? wq : hq;
      end else begin
         fdim = tr;
      end
      s_sat        = (cfg.softness > ONE_Q16) ? ONE_Q16 : cfg.softness;
      rest_t       = ONE_Q16 - t1_ff;
      t2_in        = t1_ff;
      prod_f2_in   = PROD_F_W'(s_sat) * PROD_F_W'(fdim);
      prod_gw2_in  = PROD_G_W'(wq) * PROD_G_W'(ROOT2_Q30);
      prod_gh2_in  = PROD_G_W'(hq) * PROD_G_W'(ROOT2_Q30);
      prod_in2_in  = PROD_D_W'(tr) * PROD_D_W'(rest_t);
      prod_out2_in = PROD_D_W'(tr) * PROD_D_W'(t1_ff);
   end

   always_comb begin
      f_sum    = {1'b0, prod_f2_ff} + (PROD_F_W + 1)'(HALF_Q16);
      gw_sum   = {1'b0, prod_gw2_ff} + (PROD_G_W + 1)'(HALF_Q30);
      gh_sum   = {1'b0, prod_gh2_ff} + (PROD_G_W + 1)'(HALF_Q30);
      inc_sum  = {1'b0, prod_in2_ff} + (PROD_D_W + 1)'(HALF_Q16);
      outc_sum = {1'b0, prod_out2_ff} + (PROD_D_W + 1)'(HALF_Q16);
      gw       = gw_sum[30 +: PIX_W + 1];
      gh       = gh_sum[30 +: PIX_W + 1];
      f3_in    = f_sum[16 +: PIX_W];
      inc3_in  = inc_sum[16 +: PIX_W];
      outc3_in = outc_sum[16 +: PIX_W];
      t3_in    = t2_ff;
      if (cfg.kind == KIND_IRIS) begin
         ax3_in = AX_W'(gw) + {1'b0, f3_in, 1'b0};
      end else begin
         ax3_in = AX_W'(tr) + AX_W'(f3_in);
      end
      ay3_in = AX_W'(gh) + {1'b0, f3_in, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage1_ready) begin
         t1_ff <= t1_in;
      end
      if (stage2_ready) begin
         t2_ff        <= t2_in;
         prod_f2_ff   <= prod_f2_in;
         prod_gw2_ff  <= prod_gw2_in;
         prod_gh2_ff  <= prod_gh2_in;
         prod_in2_ff  <= prod_in2_in;
         prod_out2_ff <= prod_out2_in;
      end
      if (stage3_ready) begin
         t3_ff    <= t3_in;
         f3_ff    <= f3_in;
         ax3_ff   <= ax3_in;
         ay3_ff   <= ay3_in;
         inc3_ff  <= inc3_in;
         outc3_ff <= outc3_in;
      end
   end

   assign s3_valid = v3_ff;
   assign s3_t     = t3_ff;
   assign s3_f     = f3_ff;
   assign s3_ax    = ax3_ff;
   assign s3_ay    = ay3_ff;
   assign s3_inc   = inc3_ff;
   assign s3_outc  = outc3_ff;

endmodule

@@ rtl/vts_back.sv @@
// Back pipeline stages: second multiplier rank, mask sums, saturation and output register.
module vts_back #(
   parameter int PIX_W = 22
) (
   input  logic                    clock,
   input  logic                    reset,
   input  vts_pkg::cfg_type        cfg,
   input  logic [PIX_W-1:0]        wq,
   input  logic [PIX_W-1:0]        hq,
   input  logic                    s3_valid,
   output logic                    s3_ready,
   input  logic [16:0]             s3_t,
   input  logic [PIX_W-1:0]        s3_f,
   input  logic [PIX_W+1:0]        s3_ax,
   input  logic [PIX_W+1:0]        s3_ay,
   input  logic [PIX_W-1:0]        s3_inc,
   input  logic [PIX_W-1:0]        s3_outc,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [22:0]      rsp_in_offset_x,
   output logic signed [22:0]      rsp_in_offset_y,
   output logic signed [22:0]      rsp_out_offset_x,
   output logic signed [22:0]      rsp_out_offset_y,
   output logic [16:0]             rsp_in_opacity,
   output logic [16:0]             rsp_out_opacity,
   output logic [16:0]             rsp_in_scale,
   output logic [1:0]              rsp_mask_shape,
   output logic [21:0]             rsp_mask_feather,
   output logic signed [24:0]      rsp_mask_width,
   output logic signed [24:0]      rsp_mask_height,
   output logic signed [23:0]      rsp_mask_centre
);
   import vts_pkg::*;

   localparam int AX_W  = PIX_W + 2;
   localparam int PP_W  = AX_W + Q16_W;
   localparam int LEN_W = PIX_W + 4;
   localparam int CN_W  = PIX_W + 20;
   localparam int MAG_W = PIX_W + 4;
   localparam int CMP_W = (MAG_W > MASK_W + 1) ? MAG_W : MASK_W + 1;

   logic stage4_ready, stage5_ready, stage6_ready;
   logic v4_ff, v4_in, v5_ff, v5_in, v6_ff, v6_in;

   logic [Q16_W-1:0] t4_ff, t4_in, t5_ff, t5_in;
   logic [PIX_W-1:0] f4_ff, f4_in, f5_ff, f5_in;
   logic [PIX_W-1:0] inc4_ff, inc4_in, inc5_ff, inc5_in;
   logic [PIX_W-1:0] outc4_ff, outc4_in, outc5_ff, outc5_in;
   logic [PP_W-1:0]  pp_x4_ff, pp_x4_in, pp_y4_ff, pp_y4_in;
   logic [LEN_W-1:0] len5_ff, len5_in, mw_r5_ff, mw_r5_in, mh_r5_ff, mh_r5_in;
   logic [CN_W-1:0]  cn_mag5_ff, cn_mag5_in;
   logic             cn_neg5_ff, cn_neg5_in;
   logic [PIX_W+1:0] across5_ff, across5_in;

   logic [OFS_W-1:0]     in_x6_ff, in_x6_in, in_y6_ff, in_y6_in;
   logic [OFS_W-1:0]     out_x6_ff, out_x6_in, out_y6_ff, out_y6_in;
   logic [OP_W-1:0]      in_op6_ff, in_op6_in, out_op6_ff, out_op6_in;
   logic [OP_W-1:0]      scale6_ff, scale6_in;
   logic [SHAPE_W-1:0]   shape6_ff, shape6_in;
   logic [FEATHER_W-1:0] feather6_ff, feather6_in;
   logic [MASK_W-1:0]    mw6_ff, mw6_in, mh6_ff, mh6_in;
   logic [CENTRE_W-1:0]  mc6_ff, mc6_in;

   logic              horizontal, forward;
   logic [PIX_W-1:0]  tr;
   logic [PP_W+1:0]   len_sum;
   logic [PP_W:0]     mw_sum, mh_sum;
   logic [CN_W-1:0]   cn_pos, cn_negpart;
   logic [CN_W:0]     mc_sum;
   logic [MAG_W-1:0]  mc_mag, mw_mag, mh_mag;
   logic              mc_neg, mw_neg, mh_neg;
   logic [MASK_W-1:0] inc_s, outc_s, len_s, across_s, mc_s, mw_s, mh_s;
   logic [CMP_W-1:0]  f_wide;
   logic [Q16_W:0]    dbl_t;
   logic [FEATHER_W-1:0] feather_s;

   function automatic logic [MASK_W-1:0] sat_field(input logic [MAG_W-1:0] mag,
                                                    input logic neg, input int bits);
      logic [CMP_W-1:0] wide;
      logic [CMP_W-1:0] lim;
      logic [CMP_W-1:0] val;
      wide = CMP_W'(mag);
      lim  = CMP_W'(1) << (bits - 1);
      if (neg) begin
         val       = (wide > lim) ? lim : wide;
         sat_field = MASK_W'(CMP_W'(0) - val);
      end else begin
         val       = (wide > lim - CMP_W'(1)) ? lim - CMP_W'(1) : wide;
         sat_field = MASK_W'(val);
      end
   endfunction

   assign stage6_ready = !v6_ff || rsp_ready;
   assign stage5_ready = !v5_ff || stage6_ready;
   assign stage4_ready = !v4_ff || stage5_ready;
   assign s3_ready     = stage4_ready;

   assign v4_in = stage4_ready ? s3_valid : v4_ff;
   assign v5_in = stage5_ready ? v4_ff : v5_ff;
   assign v6_in = stage6_ready ? v5_ff : v6_ff;

   assign horizontal = (cfg.direction == DIR_RIGHT) || (cfg.direction == DIR_LEFT);
   assign forward    = (cfg.direction == DIR_RIGHT) || (cfg.direction == DIR_DOWN);
   assign tr         = horizontal ? wq : hq;

   always_comb begin
      pp_x4_in = PP_W'(s3_t) * PP_W'(s3_ax);
      pp_y4_in = PP_W'(s3_t) * PP_W'(s3_ay);
      t4_in    = s3_t;
      f4_in    = s3_f;
      inc4_in  = s3_inc;
      outc4_in = s3_outc;
   end

   always_comb begin
      len_sum    = (PP_W + 2)'(pp_x4_ff) + (PP_W + 2)'({f4_ff, 15'b0})
                   + (PP_W + 2)'(HALF_Q16);
      len5_in    = len_sum[16 +: LEN_W];
      mw_sum     = {1'b0, pp_x4_ff} + (PP_W + 1)'(HALF_Q16);
      mh_sum     = {1'b0, pp_y4_ff} + (PP_W + 1)'(HALF_Q16);
      mw_r5_in   = mw_sum[16 +: LEN_W];
      mh_r5_in   = mh_sum[16 +: LEN_W];
      cn_pos     = CN_W'(pp_x4_ff);
      cn_negpart = CN_W'({tr, 16'b0}) + CN_W'({f4_ff, 16'b0}) + CN_W'({f4_ff, 15'b0});
      cn_neg5_in = cn_pos < cn_negpart;
      cn_mag5_in = cn_neg5_in ? (cn_negpart - cn_pos) : (cn_pos - cn_negpart);
      across5_in = (PIX_W + 2)'(horizontal ? hq : wq) + (PIX_W + 2)'({f4_ff, 1'b0});
      t5_in      = t4_ff;
      f5_in      = f4_ff;
      inc5_in    = inc4_ff;
      outc5_in   = outc4_ff;
   end

   always_comb begin
      mc_sum    = {1'b0, cn_mag5_ff} + (CN_W + 1)'(HALF_Q17);
      mc_mag    = mc_sum[17 +: MAG_W];
      mc_neg    = cn_neg5_ff ^ !forward;
      mw_neg    = MAG_W'(mw_r5_ff) < MAG_W'(f5_ff);
      mh_neg    = MAG_W'(mh_r5_ff) < MAG_W'(f5_ff);
      mw_mag    = mw_neg ? MAG_W'(f5_ff) - MAG_W'(mw_r5_ff) : MAG_W'(mw_r5_ff) - MAG_W'(f5_ff);
      mh_mag    = mh_neg ? MAG_W'(f5_ff) - MAG_W'(mh_r5_ff) : MAG_W'(mh_r5_ff) - MAG_W'(f5_ff);
      inc_s     = sat_field(MAG_W'(inc5_ff), forward, OFS_W);
      outc_s    = sat_field(MAG_W'(outc5_ff), !forward, OFS_W);
      len_s     = sat_field(MAG_W'(len5_ff), 1'b0, MASK_W);
      across_s  = sat_field(MAG_W'(across5_ff), 1'b0, MASK_W);
      mc_s      = sat_field(mc_mag, mc_neg, CENTRE_W);
      mw_s      = sat_field(mw_mag, mw_neg, MASK_W);
      mh_s      = sat_field(mh_mag, mh_neg, MASK_W);
      f_wide    = CMP_W'(f5_ff);
      feather_s = (f_wide > CMP_W'(FEATHER_MAX)) ? FEATHER_MAX : FEATHER_W'(f_wide);
      dbl_t     = {t5_ff, 1'b0};
   end

   always_comb begin
      in_x6_in    = '0;
      in_y6_in    = '0;
      out_x6_in   = '0;
      out_y6_in   = '0;
      in_op6_in   = ONE_Q16;
      out_op6_in  = ONE_Q16;
      scale6_in   = ONE_Q16;
      shape6_in   = SHAPE_NONE;
      feather6_in = '0;
      mw6_in      = '0;
      mh6_in      = '0;
      mc6_in      = '0;
      unique case (cfg.kind)
         KIND_WIPE: begin
            shape6_in   = SHAPE_RECT;
            feather6_in = feather_s;
            mc6_in      = mc_s[CENTRE_W-1:0];
            if (horizontal) begin
               mw6_in = len_s;
               mh6_in = across_s;
            end else begin
               mw6_in = across_s;
               mh6_in = len_s;
            end
         end
         KIND_SLIDE, KIND_PUSH: begin
            if (horizontal) begin
               in_x6_in = inc_s[OFS_W-1:0];
               if (cfg.kind == KIND_PUSH) begin
                  out_x6_in = outc_s[OFS_W-1:0];
               end
            end else begin
               in_y6_in = inc_s[OFS_W-1:0];
               if (cfg.kind == KIND_PUSH) begin
                  out_y6_in = outc_s[OFS_W-1:0];
               end
            end
         end
         KIND_IRIS: begin
            shape6_in   = SHAPE_ELLIPSE;
            feather6_in = feather_s;
            mw6_in      = mw_s;
            mh6_in      = mh_s;
         end
         KIND_ZOOM: begin
            scale6_in = t5_ff;
         end
         KIND_DIP: begin
            out_op6_in = (dbl_t >= (Q16_W + 1)'(ONE_Q16)) ? '0
                         : OP_W'((Q16_W + 1)'(ONE_Q16) - dbl_t);
            in_op6_in  = (dbl_t <= (Q16_W + 1)'(ONE_Q16)) ? '0
                         : OP_W'(dbl_t - (Q16_W + 1)'(ONE_Q16));
         end
         default: begin
            in_op6_in = t5_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage4_ready) begin
         pp_x4_ff <= pp_x4_in;
         pp_y4_ff <= pp_y4_in;
         t4_ff    <= t4_in;
         f4_ff    <= f4_in;
         inc4_ff  <= inc4_in;
         outc4_ff <= outc4_in;
      end
      if (stage5_ready) begin
         len5_ff    <= len5_in;
         mw_r5_ff   <= mw_r5_in;
         mh_r5_ff   <= mh_r5_in;
         cn_mag5_ff <= cn_mag5_in;
         cn_neg5_ff <= cn_neg5_in;
         across5_ff <= across5_in;
         t5_ff      <= t5_in;
         f5_ff      <= f5_in;
         inc5_ff    <= inc5_in;
         outc5_ff   <= outc5_in;
      end
      if (stage6_ready) begin
         in_x6_ff    <= in_x6_in;
         in_y6_ff    <= in_y6_in;
         out_x6_ff   <= out_x6_in;
         out_y6_ff   <= out_y6_in;
         in_op6_ff   <= in_op6_in;
         out_op6_ff  <= out_op6_in;
         scale6_ff   <= scale6_in;
         shape6_ff   <= shape6_in;
         feather6_ff <= feather6_in;
         mw6_ff      <= mw6_in;
         mh6_ff      <= mh6_in;
         mc6_ff      <= mc6_in;
      end
   end

   assign rsp_valid        = v6_ff;
   assign rsp_in_offset_x  = $signed(in_x6_ff);
   assign rsp_in_offset_y  = $signed(in_y6_ff);
   assign rsp_out_offset_x = $signed(out_x6_ff);
   assign rsp_out_offset_y = $signed(out_y6_ff);
   assign rsp_in_opacity   = in_op6_ff;
   assign rsp_out_opacity  = out_op6_ff;
   assign rsp_in_scale     = scale6_ff;
   assign rsp_mask_shape   = shape6_ff;
   assign rsp_mask_feather = feather6_ff;
   assign rsp_mask_width   = $signed(mw6_ff);
   assign rsp_mask_height  = $signed(mh6_ff);
   assign rsp_mask_centre  = $signed(mc6_ff);

endmodule

@@ rtl/video_transition_shape.sv @@
// Top level of the video transition shape block: control registers and the six-stage pipeline.
//
//   Channel   Signals                          Direction  Transfer
//   req       req_valid/req_ready, progress    in         valid and ready high at clock edge
//   rsp       rsp_valid/rsp_ready, 12 fields   out        valid and ready high at clock edge
//   csr       csr_we, csr_index, csr_wdata     in         csr_we high at clock edge
//
// A progress value passes through the six register stages around the two multiplier ranks
// to the response register; one transfer per cycle is sustained while rsp_ready is high.
// Reset empties the pipeline and loads the control registers with their defaults. Each
// stage moves whenever it is empty or the stage after it moves, so a stalled response
// holds while earlier stages keep filling their empty slots.
module video_transition_shape #(
   parameter int DIM_BITS  = 14,
   parameter int FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [16:0]             csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [17:0]      req_progress,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [22:0]      rsp_in_offset_x,
   output logic signed [22:0]      rsp_in_offset_y,
   output logic signed [22:0]      rsp_out_offset_x,
   output logic signed [22:0]      rsp_out_offset_y,
   output logic [16:0]             rsp_in_opacity,
   output logic [16:0]             rsp_out_opacity,
   output logic [16:0]             rsp_in_scale,
   output logic [1:0]              rsp_mask_shape,
   output logic [21:0]             rsp_mask_feather,
   output logic signed [24:0]      rsp_mask_width,
   output logic signed [24:0]      rsp_mask_height,
   output logic signed [23:0]      rsp_mask_centre
);
   import vts_pkg::*;

   localparam int DIM_W = (DIM_BITS < DIM_REG_W) ? DIM_BITS : DIM_REG_W;
   localparam int PIX_W = DIM_W + FRAC_BITS;

   cfg_type cfg_ff, cfg_in;

   logic [PIX_W-1:0] wq, hq;
   logic             s3_valid, s3_ready;
   logic [16:0]      s3_t;
   logic [PIX_W-1:0] s3_f, s3_inc, s3_outc;
   logic [PIX_W+1:0] s3_ax, s3_ay;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KIND:      cfg_in.kind         = csr_wdata[KIND_W-1:0];
            CSR_DIRECTION: cfg_in.direction    = csr_wdata[DIR_W-1:0];
            CSR_SOFTNESS:  cfg_in.softness     = csr_wdata[SOFT_W-1:0];
            CSR_WIDTH:     cfg_in.frame_width  = csr_wdata[DIM_REG_W-1:0];
            CSR_HEIGHT:    cfg_in.frame_height = csr_wdata[DIM_REG_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kind         <= KIND_DISSOLVE;
         cfg_ff.direction    <= DIR_RIGHT;
         cfg_ff.softness     <= '0;
         cfg_ff.frame_width  <= WIDTH_RESET;
         cfg_ff.frame_height <= HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign wq = {cfg_ff.frame_width[DIM_W-1:0], {FRAC_BITS{1'b0}}};
   assign hq = {cfg_ff.frame_height[DIM_W-1:0], {FRAC_BITS{1'b0}}};

   vts_front #(
      .PIX_W(PIX_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .wq           (wq),
      .hq           (hq),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_progress (req_progress),
      .s3_valid     (s3_valid),
      .s3_ready     (s3_ready),
      .s3_t         (s3_t),
      .s3_f         (s3_f),
      .s3_ax        (s3_ax),
      .s3_ay        (s3_ay),
      .s3_inc       (s3_inc),
      .s3_outc      (s3_outc)
   );

   vts_back #(
      .PIX_W(PIX_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .wq               (wq),
      .hq               (hq),
      .s3_valid         (s3_valid),
      .s3_ready         (s3_ready),
      .s3_t             (s3_t),
      .s3_f             (s3_f),
      .s3_ax            (s3_ax),
      .s3_ay            (s3_ay),
      .s3_inc           (s3_inc),
      .s3_outc          (s3_outc),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_in_offset_x  (rsp_in_offset_x),
      .rsp_in_offset_y  (rsp_in_offset_y),
      .rsp_out_offset_x (rsp_out_offset_x),
      .rsp_out_offset_y (rsp_out_offset_y),
      .rsp_in_opacity   (rsp_in_opacity),
      .rsp_out_opacity  (rsp_out_opacity),
      .rsp_in_scale     (rsp_in_scale),
      .rsp_mask_shape   (rsp_mask_shape),
      .rsp_mask_feather (rsp_mask_feather),
      .rsp_mask_width   (rsp_mask_width),
      .rsp_mask_height  (rsp_mask_height),
      .rsp_mask_centre  (rsp_mask_centre)
   );

endmodule

@@ bench/tb_video_transition_shape.sv @@
// Self-checking testbench for video_transition_shape, with a transition parameter predictor.
`timescale 1ns / 1ps

module tb_video_transition_shape;
   import vts_pkg::*;

   localparam int                FRAC        = 8;
   localparam int                TOTAL_ITEMS = 1900;
   localparam int                MAX_IDLE    = 14;
   localparam logic [KIND_W-1:0] KIND_OTHER  = 3'd7;

   typedef struct packed {
      logic signed [OFS_W-1:0]    in_x;
      logic signed [OFS_W-1:0]    in_y;
      logic signed [OFS_W-1:0]    out_x;
      logic signed [OFS_W-1:0]    out_y;
      logic [OP_W-1:0]            in_op;
      logic [OP_W-1:0]            out_op;
      logic [OP_W-1:0]            scale;
      logic [SHAPE_W-1:0]         shape;
      logic [FEATHER_W-1:0]       feather;
      logic signed [MASK_W-1:0]   mask_w;
      logic signed [MASK_W-1:0]   mask_h;
      logic signed [CENTRE_W-1:0] centre;
   } comp_params_t;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [DIR_W-1:0]         dir;
      logic [SOFT_W-1:0]        softness;
      logic [DIM_REG_W-1:0]     w;
      logic [DIM_REG_W-1:0]     h;
      logic signed [PROG_W-1:0] prog;
      logic                     known;
      logic [OP_W-1:0]          in_op;
      logic [OP_W-1:0]          out_op;
      logic [OP_W-1:0]          scale;
   } script_row_t;

   logic                       clock;
   logic                       reset       = 1'b1;
   logic                       csr_we      = 1'b0;
   logic [2:0]                 csr_index   = '0;
   logic [16:0]                csr_wdata   = '0;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   logic signed [17:0]         req_progress = '0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   logic signed [22:0]         rsp_in_offset_x;
   logic signed [22:0]         rsp_in_offset_y;
   logic signed [22:0]         rsp_out_offset_x;
   logic signed [22:0]         rsp_out_offset_y;
   logic [16:0]                rsp_in_opacity;
   logic [16:0]                rsp_out_opacity;
   logic [16:0]                rsp_in_scale;
   logic [1:0]                 rsp_mask_shape;
   logic [21:0]                rsp_mask_feather;
   logic signed [24:0]         rsp_mask_width;
   logic signed [24:0]         rsp_mask_height;
   logic signed [23:0]         rsp_mask_centre;

   cfg_type      cfg;
   comp_params_t pending_params[$];
   int           mismatches = 0;
   int           sent       = 0;
   bit           req_calm   = 1'b0;
   bit           rsp_calm   = 1'b0;

   script_row_t script [0:23] = '{
      '{KIND_DISSOLVE, DIR_RIGHT, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'h20000, 1'b1,
        17'd0, 17'd65536, 17'd65536},
      '{KIND_DISSOLVE, DIR_RIGHT, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'h1FFFF, 1'b1,
        17'd65536, 17'd65536, 17'd65536},
      '{KIND_DISSOLVE, DIR_RIGHT, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'sd32768, 1'b1,
        17'd32768, 17'd65536, 17'd65536},
      '{KIND_OTHER, DIR_RIGHT, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'sd16384, 1'b1,
        17'd16384, 17'd65536, 17'd65536},
      '{KIND_ZOOM, DIR_RIGHT, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'h3FFFF, 1'b1,
        17'd65536, 17'd65536, 17'd0},
      '{KIND_ZOOM, DIR_RIGHT, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'sd65537, 1'b1,
        17'd65536, 17'd65536, 17'd65536},
      '{KIND_DIP, DIR_RIGHT, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'sd0, 1'b1,
        17'd0, 17'd65536, 17'd65536},
      '{KIND_DIP, DIR_RIGHT, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'sd16384, 1'b1,
        17'd0, 17'd32768, 17'd65536},
      '{KIND_DIP, DIR_RIGHT, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'sd32768, 1'b1,
        17'd0, 17'd0, 17'd65536},
      '{KIND_DIP, DIR_RIGHT, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'sd65536, 1'b1,
        17'd65536, 17'd0, 17'd65536},
      '{KIND_WIPE, DIR_RIGHT, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'sd0, 1'b0,
        17'd0, 17'd0, 17'd0},
      '{KIND_WIPE, DIR_LEFT, 17'd65536, WIDTH_RESET, HEIGHT_RESET, 18'sd32768, 1'b0,
        17'd0, 17'd0, 17'd0},
      '{KIND_WIPE, DIR_DOWN, 17'd131071, WIDTH_RESET, HEIGHT_RESET, 18'sd65536, 1'b0,
        17'd0, 17'd0, 17'd0},
      '{KIND_WIPE, DIR_UP, 17'd20000, 14'd16383, 14'd16383, 18'sd49152, 1'b0,
        17'd0, 17'd0, 17'd0},
      '{KIND_WIPE, DIR_RIGHT, 17'd65536, 14'd1, 14'd1, 18'sd1, 1'b0,
        17'd0, 17'd0, 17'd0},
      '{KIND_SLIDE, DIR_RIGHT, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'sd16384, 1'b0,
        17'd0, 17'd0, 17'd0},
      '{KIND_SLIDE, DIR_UP, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'sd65536, 1'b0,
        17'd0, 17'd0, 17'd0},
      '{KIND_SLIDE, DIR_RIGHT, 17'd0, 14'd0, 14'd0, 18'sd1000, 1'b0,
        17'd0, 17'd0, 17'd0},
      '{KIND_PUSH, DIR_LEFT, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'sd40000, 1'b0,
        17'd0, 17'd0, 17'd0},
      '{KIND_PUSH, DIR_DOWN, 17'd0, WIDTH_RESET, HEIGHT_RESET, 18'sd0, 1'b0,
        17'd0, 17'd0, 17'd0},
      '{KIND_PUSH, DIR_UP, 17'd0, 14'd16383, 14'd16383, 18'sd65535, 1'b0,
        17'd0, 17'd0, 17'd0},
      '{KIND_IRIS, DIR_RIGHT, 17'd65536, WIDTH_RESET, HEIGHT_RESET, 18'sd0, 1'b0,
        17'd0, 17'd0, 17'd0},
      '{KIND_IRIS, DIR_RIGHT, 17'd32768, 14'd16383, 14'd1, 18'sd65536, 1'b0,
        17'd0, 17'd0, 17'd0},
      '{KIND_IRIS, DIR_DOWN, 17'd65536, 14'd0, 14'd0, 18'sd30000, 1'b0,
        17'd0, 17'd0, 17'd0}
   };

   video_transition_shape u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_video_transition_shape: FAIL");
      $finish;
   end

   function automatic longint round_shift(input longint v, input int sh);
      longint m;
      longint r;
      m = (v < 0) ? -v : v;
      r = (m + (longint'(1) << (sh - 1))) >>> sh;
      return (v < 0) ? -r : r;
   endfunction

   function automatic longint clamp_signed(input longint v, input int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
   endfunction

   function automatic longint clamp_range(input longint v, input longint hi);
      return (v < 0) ? 0 : ((v > hi) ? hi : v);
   endfunction

   function automatic comp_params_t transition_params(input logic signed [PROG_W-1:0] prog,
                                                      input cfg_type c);
      longint       t, s, wq, hq, tr, f, pp, len, cn, across, d, inc, outc, m, gw, gh;
      longint       in_x, in_y, out_x, out_y, in_op, out_op, scale;
      longint       shape, feather, mw, mh, mc;
      bit           horiz, fwd;
      comp_params_t r;
      t = prog;
      t = (t < 0) ? 0 : ((t > 65536) ? 65536 : t);
      s = (c.softness > ONE_Q16) ? 65536 : longint'(c.softness);
      wq = longint'(c.frame_width) << FRAC;
      hq = longint'(c.frame_height) << FRAC;
      horiz = (c.direction == DIR_RIGHT) || (c.direction == DIR_LEFT);
      fwd = (c.direction == DIR_RIGHT) || (c.direction == DIR_DOWN);
      in_x = 0; in_y = 0; out_x = 0; out_y = 0;
      in_op = 65536; out_op = 65536; scale = 65536;
      shape = SHAPE_NONE; feather = 0; mw = 0; mh = 0; mc = 0;
      case (c.kind)
         KIND_WIPE: begin
            tr = horiz ? wq : hq;
            f = round_shift(s * tr, 16);
            pp = t * (tr + f);
            len = round_shift(f * 32768 + pp, 16);
            cn = pp - tr * 65536 - f * 98304;
            across = (horiz ? hq : wq) + 2 * f;
            if (!fwd) cn = -cn;
            mc = round_shift(cn, 17);
            shape = SHAPE_RECT;
            feather = f;
            if (horiz) begin
               mw = len; mh = across;
            end else begin
               mh = len; mw = across;
            end
         end
         KIND_SLIDE, KIND_PUSH: begin
            d = horiz ? wq : hq;
            inc = round_shift(d * (65536 - t), 16);
            outc = (c.kind == KIND_PUSH) ? round_shift(d * t, 16) : 0;
            if (fwd) inc = -inc;
            else outc = -outc;
            if (horiz) begin
               in_x = inc; out_x = outc;
            end else begin
               in_y = inc; out_y = outc;
            end
         end
         KIND_IRIS: begin
            m = (wq < hq) ? wq : hq;
            f = round_shift(s * m, 16);
            gw = round_shift(wq * longint'(ROOT2_Q30), 30);
            gh = round_shift(hq * longint'(ROOT2_Q30), 30);
            shape = SHAPE_ELLIPSE;
            feather = f;
            mw = round_shift(t * (gw + 2 * f), 16) - f;
            mh = round_shift(t * (gh + 2 * f), 16) - f;
         end
         KIND_ZOOM: scale = t;
         KIND_DIP: begin
            out_op = clamp_range(65536 - 2 * t, 65536);
            in_op = clamp_range(2 * t - 65536, 65536);
         end
         default: in_op = t;
      endcase
      r.in_x    = OFS_W'(clamp_signed(in_x, OFS_W));
      r.in_y    = OFS_W'(clamp_signed(in_y, OFS_W));
      r.out_x   = OFS_W'(clamp_signed(out_x, OFS_W));
      r.out_y   = OFS_W'(clamp_signed(out_y, OFS_W));
      r.in_op   = OP_W'(in_op);
      r.out_op  = OP_W'(out_op);
      r.scale   = OP_W'(scale);
      r.shape   = SHAPE_W'(shape);
      r.feather = FEATHER_W'(clamp_range(feather, longint'(FEATHER_MAX)));
      r.mask_w  = MASK_W'(clamp_signed(mw, MASK_W));
      r.mask_h  = MASK_W'(clamp_signed(mh, MASK_W));
      r.centre  = CENTRE_W'(clamp_signed(mc, CENTRE_W));
      return r;
   endfunction

   function automatic logic [DIM_REG_W-1:0] random_dim();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return DIM_REG_W'(1);
         2: return DIM_REG_W'(16383);
         3: return DIM_REG_W'($urandom_range(1, 16383));
         default: return DIM_REG_W'($urandom_range(16, 4096));
      endcase
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.kind = KIND_W'($urandom_range(0, 7));
      c.direction = DIR_W'($urandom_range(0, 3));
      case ($urandom_range(0, 4))
         0: c.softness = '0;
         1: c.softness = ONE_Q16;
         2: c.softness = SOFT_W'(131071);
         3: c.softness = SOFT_W'($urandom_range(0, 131071));
         default: c.softness = SOFT_W'($urandom_range(0, 65536));
      endcase
      c.frame_width = random_dim();
      c.frame_height = random_dim();
      return c;
   endfunction

   function automatic logic signed [PROG_W-1:0] random_progress();
      int corner [8] = '{-131072, -1, 0, 1, 65535, 65536, 65537, 131071};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return PROG_W'($urandom_range(0, 65536));
         6, 7: return PROG_W'($urandom);
         8: return PROG_W'(corner[$urandom_range(0, 7)]);
         default: return PROG_W'($urandom_range(0, 63) + ($urandom_range(0, 1) ? 65473 : 0));
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   // The block must be empty before its registers change.
   task automatic reconfigure(input cfg_type c);
      req_valid <= 1'b0;
      while (pending_params.size() != 0) @(posedge clock);
      write_csr(CSR_KIND, CSR_DATA_W'(c.kind));
      write_csr(CSR_DIRECTION, CSR_DATA_W'(c.direction));
      write_csr(CSR_SOFTNESS, CSR_DATA_W'(c.softness));
      write_csr(CSR_WIDTH, CSR_DATA_W'(c.frame_width));
      write_csr(CSR_HEIGHT, CSR_DATA_W'(c.frame_height));
      csr_we <= 1'b0;
      cfg = c;
   endtask

   task automatic send_progress(input logic signed [PROG_W-1:0] p, input comp_params_t want);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_progress <= p;
      do @(posedge clock); while (!req_ready);
      pending_params.push_back(want);
      sent++;
   endtask

   task automatic compare_params(input comp_params_t want);
      check_field("in_offset_x", rsp_in_offset_x, want.in_x);
      check_field("in_offset_y", rsp_in_offset_y, want.in_y);
      check_field("out_offset_x", rsp_out_offset_x, want.out_x);
      check_field("out_offset_y", rsp_out_offset_y, want.out_y);
      check_field("in_opacity", rsp_in_opacity, want.in_op);
      check_field("out_opacity", rsp_out_opacity, want.out_op);
      check_field("in_scale", rsp_in_scale, want.scale);
      check_field("mask_shape", rsp_mask_shape, want.shape);
      check_field("mask_feather", rsp_mask_feather, want.feather);
      check_field("mask_width", rsp_mask_width, want.mask_w);
      check_field("mask_height", rsp_mask_height, want.mask_h);
      check_field("mask_centre", rsp_mask_centre, want.centre);
   endtask

   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = rsp_calm ? 0 : $urandom_range(0, MAX_IDLE);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_params.size() == 0) report_mismatch("response transfer with none expected");
         else compare_params(pending_params.pop_front());
      end
   end

   initial begin
      script_row_t  row;
      cfg_type      next_cfg;
      comp_params_t want;
      int           phase_items;
      logic signed [PROG_W-1:0] p;
      cfg = {KIND_DISSOLVE, DIR_RIGHT, {SOFT_W{1'b0}}, WIDTH_RESET, HEIGHT_RESET};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(script); i++) begin
         row = script[i];
         next_cfg = {row.kind, row.dir, row.softness, row.w, row.h};
         if (next_cfg != cfg) reconfigure(next_cfg);
         if (row.known) begin
            want = '0;
            want.in_op = row.in_op;
            want.out_op = row.out_op;
            want.scale = row.scale;
         end else begin
            want = transition_params(row.prog, cfg);
         end
         send_progress(row.prog, want);
      end

      while (sent < TOTAL_ITEMS) begin
         reconfigure(random_cfg());
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         phase_items = $urandom_range(10, 80);
         for (int i = 0; i < phase_items; i++) begin
            p = random_progress();
            send_progress(p, transition_params(p, cfg));
         end
      end

      req_valid <= 1'b0;
      while (pending_params.size() != 0) @(posedge clock);
      rsp_calm = 1'b1;
      repeat (32) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_video_transition_shape: PASS");
      end else begin
         $display("tb_video_transition_shape: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/vts_pkg.sv
rtl/vts_front.sv
rtl/vts_back.sv
rtl/video_transition_shape.sv
bench/tb_video_transition_shape.sv
